// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Shared sizes, operation codes and result status codes.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Number of block table entries.
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int ADDR_W   = 32;
  localparam int REC_W    = 16;
  localparam int STATUS_W = 3;
  localparam int ALIGN_W  = 5;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_ZERO = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_ALIGN = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
  localparam logic [ADDR_W-1:0]  SIZE_RST  = 32'd16777216;
  localparam logic [ALIGN_W-1:0] ALIGN_RST = 5'd6;

endpackage

// ===== rtl/core/bfa_if.sv =====
// ----------------------------------------------------------------------------
// Best-fit block allocator channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel.
interface bfa_in_if
  import bfa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, operation, request_size, free_address, input ready);
  modport sink   (input valid, operation, request_size, free_address, output ready);
endinterface

// Result channel.
interface bfa_out_if
  import bfa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   block_address;
  logic [ADDR_W-1:0]   granted_size;
  logic [STATUS_W-1:0] status;

  modport source (output valid, block_address, granted_size, status, input ready);
  modport sink   (input valid, block_address, granted_size, status, output ready);
endinterface

// ===== rtl/core/best_fit_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Best-fit block allocator core
// Block table with best-fit allocation, splitting and coalescing on free.
// ----------------------------------------------------------------------------
// The block table lives in simple dual-port memories (start, length, recency,
// rank) that one sequencer walks an entry per cycle through a shared compare
// and adder path. An allocate makes one pass over the table for the best-fit
// search, then updates the entries; a free makes one pass to find the block
// and one for its neighbors. When the recency stamp counter reaches its top
// value, the stamps of free blocks are renumbered first. After reset and after
// each configuration write the table is rebuilt as at most one free block. The
// block takes one request at a time; a finished result waits in the output
// register while the next request is accepted.
module best_fit_block_allocator_core
  import bfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  bfa_in_if.sink             in_ch,
  bfa_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Sequencer state codes.
  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_A_CHK   = 5'd2;
  localparam logic [4:0] S_A_SCAN  = 5'd3;
  localparam logic [4:0] S_A_UPD   = 5'd4;
  localparam logic [4:0] S_A_UPD2  = 5'd5;
  localparam logic [4:0] S_F_CHK   = 5'd6;
  localparam logic [4:0] S_F_SCAN1 = 5'd7;
  localparam logic [4:0] S_F_SCAN2 = 5'd8;
  localparam logic [4:0] S_F_UPD   = 5'd9;
  localparam logic [4:0] S_F_UPD2  = 5'd10;
  localparam logic [4:0] S_F_UPD3  = 5'd11;
  localparam logic [4:0] S_STAMP   = 5'd12;
  localparam logic [4:0] S_RN_A    = 5'd13;
  localparam logic [4:0] S_RN_B    = 5'd14;
  localparam logic [4:0] S_RN_C    = 5'd15;
  localparam logic [4:0] S_RN_W    = 5'd16;
  localparam logic [4:0] S_FIN     = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_BLOCKS);
  localparam logic [REC_W-1:0] REC_TOP  = {REC_W{1'b1}};

  // Configuration registers.
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0]  size_r, size_nxt;
  logic [ALIGN_W-1:0] alog_r, alog_nxt;
  logic [ADDR_W-1:0]  usable_r, usable_nxt;

  // Sequencer and working registers.
  logic [4:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              op_r, op_nxt;
  logic [ADDR_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W:0]   want_r, want_nxt;
  logic              bf_r, bf_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [ADDR_W-1:0] bstart_r, bstart_nxt;
  logic [ADDR_W-1:0] blen_r, blen_nxt;
  logic [REC_W-1:0]  brec_r, brec_nxt;
  logic              sf_r, sf_nxt;
  logic [IDX_W-1:0]  spare_r, spare_nxt;
  logic [ADDR_W-1:0] fend_r, fend_nxt;
  logic              sc_r, sc_nxt;
  logic [IDX_W-1:0]  sidx_r, sidx_nxt;
  logic [ADDR_W-1:0] slen_r, slen_nxt;
  logic              pf_r, pf_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [ADDR_W-1:0] pstart_r, pstart_nxt;
  logic [ADDR_W-1:0] plen_r, plen_nxt;
  logic [REC_W-1:0]  rcnt_r, rcnt_nxt;
  logic [IDX_W-1:0]  target_r, target_nxt;
  logic [CNT_W-1:0]  ri_r, ri_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [REC_W-1:0]  refrec_r, refrec_nxt;
  logic [IDX_W-1:0]  rank_r, rank_nxt;
  logic [ADDR_W-1:0] raddr_r, raddr_nxt;
  logic [ADDR_W-1:0] rsize_r, rsize_nxt;
  logic [STATUS_W-1:0] rstat_r, rstat_nxt;
  logic [MAX_BLOCKS-1:0] valid_r, valid_nxt;
  logic [MAX_BLOCKS-1:0] inuse_r, inuse_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [ADDR_W-1:0]   out_size_r, out_size_nxt;
  logic [STATUS_W-1:0] out_stat_r, out_stat_nxt;

  // Table memories and their registered read data.
  logic [ADDR_W-1:0] start_mem [MAX_BLOCKS];
  logic [ADDR_W-1:0] len_mem   [MAX_BLOCKS];
  logic [REC_W-1:0]  rec_mem   [MAX_BLOCKS];
  logic [IDX_W-1:0]  rank_mem  [MAX_BLOCKS];
  logic [ADDR_W-1:0] start_q, len_q;
  logic [REC_W-1:0]  rec_q;
  logic [IDX_W-1:0]  rank_q;

  // Memory port controls.
  logic [IDX_W-1:0]  rd_idx;
  logic              start_we, len_we, rec_we, rank_we;
  logic [IDX_W-1:0]  start_wa, len_wa, rec_wa, rank_wa;
  logic [ADDR_W-1:0] start_wd, len_wd;
  logic [REC_W-1:0]  rec_wd;
  logic [IDX_W-1:0]  rank_wd;

  // Shared datapath terms.
  logic [CNT_W-1:0]  km1;
  logic [IDX_W-1:0]  eidx;
  logic              e_free;
  logic [ADDR_W:0]   unit_w, unit_mask;
  logic [ADDR_W:0]   up_w, adj_w, round_w;
  logic [ADDR_W-1:0] rem_w, e_end;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign km1     = k_r - 1'b1;
  assign eidx    = km1[IDX_W-1:0];
  assign e_free  = valid_r[eidx] & ~inuse_r[eidx];
  assign unit_w  = (ADDR_W+1)'(1) << alog_r;
  assign unit_mask = unit_w - 1'b1;
  assign up_w    = ({1'b0, base_r} + unit_mask) & ~unit_mask;
  assign adj_w   = up_w - {1'b0, base_r};
  assign round_w = ({1'b0, req_r} + unit_mask) & ~unit_mask;
  assign rem_w   = blen_r - want_r[ADDR_W-1:0];
  assign e_end   = start_q + len_q;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  // Configuration read-back.
  assign pready = 1'b1;
  always_comb begin
    unique case (cfg_idx)
      REG_BASE:  prdata = base_r;
      REG_SIZE:  prdata = size_r;
      REG_ALIGN: prdata = {{(PDATA_W-ALIGN_W){1'b0}}, alog_r};
      default:   prdata = '0;
    endcase
  end

  // Channel outputs.
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.granted_size  = out_size_r;
  assign out_ch.status        = out_stat_r;

  // Memory read address: the scan counter, or the entry being ranked.
  always_comb begin
    if (state_r == S_RN_A) begin
      rd_idx = ri_r[IDX_W-1:0];
    end else begin
      rd_idx = k_r[IDX_W-1:0];
    end
  end

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt = state_r;     k_nxt = k_r;           op_nxt = op_r;
    req_nxt = req_r;         addr_nxt = addr_r;     want_nxt = want_r;
    bf_nxt = bf_r;           best_nxt = best_r;     bstart_nxt = bstart_r;
    blen_nxt = blen_r;       brec_nxt = brec_r;     sf_nxt = sf_r;
    spare_nxt = spare_r;     fend_nxt = fend_r;     sc_nxt = sc_r;
    sidx_nxt = sidx_r;       slen_nxt = slen_r;     pf_nxt = pf_r;
    pidx_nxt = pidx_r;       pstart_nxt = pstart_r; plen_nxt = plen_r;
    rcnt_nxt = rcnt_r;       target_nxt = target_r; ri_nxt = ri_r;
    n_nxt = n_r;             refrec_nxt = refrec_r; rank_nxt = rank_r;
    raddr_nxt = raddr_r;     rsize_nxt = rsize_r;   rstat_nxt = rstat_r;
    valid_nxt = valid_r;     inuse_nxt = inuse_r;
    base_nxt = base_r;       size_nxt = size_r;     alog_nxt = alog_r;
    usable_nxt = usable_r;
    out_valid_nxt = out_valid_r; out_addr_nxt = out_addr_r;
    out_size_nxt = out_size_r;   out_stat_nxt = out_stat_r;
    start_we = 1'b0; start_wa = '0; start_wd = '0;
    len_we = 1'b0;   len_wa = '0;   len_wd = '0;
    rec_we = 1'b0;   rec_wa = '0;   rec_wd = '0;
    rank_we = 1'b0;  rank_wa = '0;  rank_wd = '0;

    // The result register empties on a transfer.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Rebuild the table as one free block at the aligned base, if the size exceeds one alignment unit.
      S_INIT: begin
        valid_nxt = '0;
        inuse_nxt = '0;
        usable_nxt = '0;
        rcnt_nxt = '0;
        if ({1'b0, size_r} > unit_w) begin
          usable_nxt = size_r - adj_w[ADDR_W-1:0];
          valid_nxt[0] = 1'b1;
          rcnt_nxt = REC_W'(1);
        end
        start_we = 1'b1; start_wa = '0; start_wd = up_w[ADDR_W-1:0];
        len_we = 1'b1;   len_wa = '0;   len_wd = size_r - adj_w[ADDR_W-1:0];
        rec_we = 1'b1;   rec_wa = '0;   rec_wd = '0;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.operation;
          req_nxt = in_ch.request_size;
          addr_nxt = in_ch.free_address;
          state_nxt = (in_ch.operation == OP_FREE) ? S_F_CHK : S_A_CHK;
        end
      end

      // Allocate: check the request and round it up.
      S_A_CHK: begin
        raddr_nxt = '0;
        rsize_nxt = '0;
        if (req_r == '0 || req_r > usable_r) begin
          rstat_nxt = ST_BAD_SIZE;
          state_nxt = S_OUT;
        end else begin
          want_nxt = round_w;
          bf_nxt = 1'b0;
          sf_nxt = 1'b0;
          k_nxt = '0;
          state_nxt = S_A_SCAN;
        end
      end

      // Allocate: best-fit search and first spare entry, one entry a cycle.
      S_A_SCAN: begin
        if (k_r != '0) begin
          if (e_free && {1'b0, len_q} >= want_r &&
              (!bf_r || len_q < blen_r || (len_q == blen_r && rec_q > brec_r))) begin
            bf_nxt = 1'b1;
            best_nxt = eidx;
            bstart_nxt = start_q;
            blen_nxt = len_q;
            brec_nxt = rec_q;
          end
          if (!valid_r[eidx] && !sf_r) begin
            sf_nxt = 1'b1;
            spare_nxt = eidx;
          end
        end
        if (k_r == SCAN_END) begin
          state_nxt = S_A_UPD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // Allocate: claim the block and split off the remainder.
      S_A_UPD: begin
        if (!bf_r) begin
          rstat_nxt = ST_NO_FIT;
          state_nxt = S_OUT;
        end else begin
          inuse_nxt[best_r] = 1'b1;
          raddr_nxt = bstart_r;
          rstat_nxt = ST_OK;
          if ({1'b0, rem_w} >= unit_w && sf_r) begin
            start_we = 1'b1; start_wa = spare_r;
            start_wd = bstart_r + want_r[ADDR_W-1:0];
            len_we = 1'b1;   len_wa = spare_r; len_wd = rem_w;
            target_nxt = spare_r;
            rsize_nxt = want_r[ADDR_W-1:0];
            state_nxt = S_A_UPD2;
          end else begin
            rsize_nxt = blen_r;
            state_nxt = S_OUT;
          end
        end
      end

      S_A_UPD2: begin
        len_we = 1'b1; len_wa = best_r; len_wd = want_r[ADDR_W-1:0];
        state_nxt = S_STAMP;
      end

      // Free: a block at address zero is never freed.
      S_F_CHK: begin
        raddr_nxt = '0;
        rsize_nxt = '0;
        if (addr_r == '0) begin
          rstat_nxt = ST_FREE_ZERO;
          state_nxt = S_OUT;
        end else begin
          bf_nxt = 1'b0;
          k_nxt = '0;
          state_nxt = S_F_SCAN1;
        end
      end

      // Free: find the in-use block that starts at the address.
      S_F_SCAN1: begin
        if (k_r != '0 && !bf_r && valid_r[eidx] && inuse_r[eidx] && start_q == addr_r) begin
          bf_nxt = 1'b1;
          best_nxt = eidx;
          bstart_nxt = start_q;
          blen_nxt = len_q;
          fend_nxt = e_end;
        end
        if (k_r == SCAN_END) begin
          if (bf_nxt) begin
            sc_nxt = 1'b0;
            pf_nxt = 1'b0;
            k_nxt = '0;
            state_nxt = S_F_SCAN2;
          end else begin
            rstat_nxt = ST_NOT_FOUND;
            state_nxt = S_OUT;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // Free: find the free neighbors after and before the block.
      S_F_SCAN2: begin
        if (k_r != '0 && e_free) begin
          if (!sc_r && start_q == fend_r) begin
            sc_nxt = 1'b1;
            sidx_nxt = eidx;
            slen_nxt = len_q;
          end else if (!pf_r && e_end == addr_r) begin
            pf_nxt = 1'b1;
            pidx_nxt = eidx;
            pstart_nxt = start_q;
            plen_nxt = len_q;
          end
        end
        if (k_r == SCAN_END) begin
          state_nxt = S_F_UPD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // Free: merge the successor.
      S_F_UPD: begin
        if (sc_r) begin
          blen_nxt = blen_r + slen_r;
          valid_nxt[sidx_r] = 1'b0;
        end
        state_nxt = S_F_UPD2;
      end

      // Free: merge the predecessor.
      S_F_UPD2: begin
        if (pf_r) begin
          blen_nxt = blen_r + plen_r;
          bstart_nxt = pstart_r;
          valid_nxt[pidx_r] = 1'b0;
        end
        state_nxt = S_F_UPD3;
      end

      S_F_UPD3: begin
        start_we = 1'b1; start_wa = best_r; start_wd = bstart_r;
        len_we = 1'b1;   len_wa = best_r;   len_wd = blen_r;
        target_nxt = best_r;
        rsize_nxt = blen_r;
        rstat_nxt = ST_OK;
        state_nxt = S_STAMP;
      end

      // Recency stamp, renumbering first when the counter is at its top.
      S_STAMP: begin
        if (rcnt_r == REC_TOP) begin
          ri_nxt = '0;
          n_nxt = '0;
          state_nxt = S_RN_A;
        end else begin
          rec_we = 1'b1; rec_wa = target_r; rec_wd = rcnt_r;
          rcnt_nxt = rcnt_r + 1'b1;
          state_nxt = S_FIN;
        end
      end

      // Renumber: pick the next free entry to rank.
      S_RN_A: begin
        if (ri_r == SCAN_END) begin
          k_nxt = '0;
          state_nxt = S_RN_W;
        end else if (valid_r[ri_r[IDX_W-1:0]] && !inuse_r[ri_r[IDX_W-1:0]]) begin
          n_nxt = n_r + 1'b1;
          state_nxt = S_RN_B;
        end else begin
          ri_nxt = ri_r + 1'b1;
        end
      end

      S_RN_B: begin
        refrec_nxt = rec_q;
        rank_nxt = '0;
        k_nxt = '0;
        state_nxt = S_RN_C;
      end

      // Renumber: count free entries with an older stamp.
      S_RN_C: begin
        if (k_r != '0 && e_free && rec_q < refrec_r) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (k_r == SCAN_END) begin
          rank_we = 1'b1; rank_wa = ri_r[IDX_W-1:0]; rank_wd = rank_nxt;
          ri_nxt = ri_r + 1'b1;
          state_nxt = S_RN_A;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // Renumber: write the ranks back as stamps.
      S_RN_W: begin
        if (k_r != '0 && e_free) begin
          rec_we = 1'b1; rec_wa = eidx; rec_wd = REC_W'(rank_q);
        end
        if (k_r == SCAN_END) begin
          rcnt_nxt = REC_W'(n_r);
          state_nxt = S_STAMP;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // Publish the new free block or release the freed one.
      S_FIN: begin
        if (op_r == OP_FREE) begin
          inuse_nxt[target_r] = 1'b0;
        end else begin
          valid_nxt[target_r] = 1'b1;
        end
        state_nxt = S_OUT;
      end

      // Hand the result to the output register once it is empty.
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt = raddr_r;
          out_size_nxt = rsize_r;
          out_stat_nxt = rstat_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // Configuration writes are to come only while idle; the core does not enforce this. Each rebuilds the table.
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE: begin
          base_nxt = pwdata;
          state_nxt = S_INIT;
        end
        REG_SIZE: begin
          size_nxt = pwdata;
          state_nxt = S_INIT;
        end
        REG_ALIGN: begin
          alog_nxt = pwdata[ALIGN_W-1:0];
          state_nxt = S_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      out_valid_r <= 1'b0;
      base_r <= BASE_RST;
      size_r <= SIZE_RST;
      alog_r <= ALIGN_RST;
      valid_r <= '0;
      inuse_r <= '0;
      rcnt_r <= '0;
      usable_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      base_r <= base_nxt;
      size_r <= size_nxt;
      alog_r <= alog_nxt;
      valid_r <= valid_nxt;
      inuse_r <= inuse_nxt;
      rcnt_r <= rcnt_nxt;
      usable_r <= usable_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    k_r <= k_nxt;           op_r <= op_nxt;         req_r <= req_nxt;
    addr_r <= addr_nxt;     want_r <= want_nxt;     bf_r <= bf_nxt;
    best_r <= best_nxt;     bstart_r <= bstart_nxt; blen_r <= blen_nxt;
    brec_r <= brec_nxt;     sf_r <= sf_nxt;         spare_r <= spare_nxt;
    fend_r <= fend_nxt;     sc_r <= sc_nxt;         sidx_r <= sidx_nxt;
    slen_r <= slen_nxt;     pf_r <= pf_nxt;         pidx_r <= pidx_nxt;
    pstart_r <= pstart_nxt; plen_r <= plen_nxt;     target_r <= target_nxt;
    ri_r <= ri_nxt;         n_r <= n_nxt;           refrec_r <= refrec_nxt;
    rank_r <= rank_nxt;     raddr_r <= raddr_nxt;   rsize_r <= rsize_nxt;
    rstat_r <= rstat_nxt;
    out_addr_r <= out_addr_nxt;
    out_size_r <= out_size_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Table memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_wa] <= start_wd;
    end
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    start_q <= start_mem[rd_idx];
    len_q <= len_mem[rd_idx];
    rec_q <= rec_mem[rd_idx];
    rank_q <= rank_mem[rd_idx];
  end

endmodule

// ===== rtl/core/bfa_checker.sv =====
// ----------------------------------------------------------------------------
// Best-fit block allocator checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module bfa_checker
  import bfa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ADDR_W-1:0]   out_block_address,
  input logic [ADDR_W-1:0]   out_granted_size,
  input logic [STATUS_W-1:0] out_status,
  input logic                pready
);

  // The core works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a request while busy");

  // A failed request returns neither an address nor a size.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_address == '0 && out_granted_size == '0)
    else $error("failure result carries data");

  // Status is always one of the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FREE_ZERO)
    else $error("undefined status code");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_address) &&
      $stable(out_granted_size) && $stable(out_status))
    else $error("result changed while stalled");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind best_fit_block_allocator_core bfa_checker u_bfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_block_address (out_ch.block_address),
  .out_granted_size  (out_ch.granted_size),
  .out_status        (out_ch.status),
  .pready            (pready)
);
